### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

  localparam int unsigned NumPriosDef = 32;
  localparam int unsigned NumTasksDef = 16;
  localparam logic [7:0]  LockMax     = 8'd255;
  localparam logic [7:0]  SliceReset  = 8'd10;

  typedef enum logic [2:0] {
    CMD_READY    = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_DELAY    = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_LOCK     = 3'd4,
    CMD_UNLOCK   = 3'd5,
    CMD_SCHEDULE = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_e;

endpackage

### hw/rtl/priority_task_scheduler_core.sv
`timescale 1ns / 1ps
// Channel | Handshake                 | Payload
// in      | in_valid_i / in_ready_o   | cmd_i, task_id_i, task_prio_i, delay_ticks_i
// out     | out_valid_o / out_ready_i | switch_now_o, next_task_o, running_task_o,
//         |                           | lock_depth_o, any_ready_o
// cfg     | cfg_we_i (no wait)        | cfg_wdata_i (time_slice_ticks)
//
// Lock, unlock, delay and schedule go straight to selection and output; remove unlinks
// the task if it is queued; ready unlinks a queued task, then pushes it at the head.
// A tick walks every task, decrements each delay count and pushes each woken task,
// then rotates the running task's queue on slice expiry; each state memory has one read port.
// Reset clears control state only; queue and link memories need no clearing pass.
// A result waits in the output register; the block holds in its last step only
// if a second result is ready while the first is still untaken.
module priority_task_scheduler_core #(
  parameter int unsigned NUM_PRIOS = pts_pkg::NumPriosDef,
  parameter int unsigned NUM_TASKS = pts_pkg::NumTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  task_id_i,
  input  logic [4:0]  task_prio_i,
  input  logic [15:0] delay_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        switch_now_o,
  output logic [3:0]  next_task_o,
  output logic [3:0]  running_task_o,
  output logic [7:0]  lock_depth_o,
  output logic        any_ready_o
);

  localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_TSCAN = 16'h0002,
    S_TDEC  = 16'h0004,
    S_U0    = 16'h0008,
    S_U1    = 16'h0010,
    S_U2    = 16'h0020,
    S_P0    = 16'h0040,
    S_P1    = 16'h0080,
    S_P2    = 16'h0100,
    S_RPRI  = 16'h0200,
    S_R0    = 16'h0400,
    S_R1    = 16'h0800,
    S_R2    = 16'h1000,
    S_R3    = 16'h2000,
    S_SEL   = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  // State memories: per-task links, priority and delay count, per-priority ends
  logic [TW-1:0] next_mem [NUM_TASKS];
  logic [TW-1:0] prev_mem [NUM_TASKS];
  logic [PW-1:0] prio_mem [NUM_TASKS];
  logic [15:0]   dly_mem  [NUM_TASKS];
  logic [TW-1:0] head_mem [NUM_PRIOS];
  logic [TW-1:0] tail_mem [NUM_PRIOS];

  logic [TW-1:0] rd_next_q, rd_prev_q, rd_head_q, rd_tail_q;
  logic [PW-1:0] rd_prio_q;
  logic [15:0]   rd_dly_q;

  logic [TW-1:0] ta, qa_t;
  logic [PW-1:0] qa;
  logic [TW-1:0] da;
  logic          next_we, prev_we, prio_we, head_we, tail_we, dly_we;
  logic [TW-1:0] next_wa, prev_wa, prio_wa, dly_wa, next_wd, prev_wd, head_wd, tail_wd;
  logic [PW-1:0] head_wa, tail_wa, prio_wd;
  logic [15:0]   dly_wd;

  state_e           state_q, state_d;
  logic [NUM_PRIOS-1:0] bitmap_q, bitmap_d;
  logic [NUM_TASKS-1:0] inq_q, inq_d, dlyf_q, dlyf_d;
  logic [TW-1:0]    t_work_q, t_work_d, h_q, h_d, cur_q, cur_d;
  logic [PW-1:0]    p_push_q, p_push_d, p_work_q, p_work_d;
  logic [TW:0]      scan_q, scan_d;
  logic             push_after_q, push_after_d, tick_mode_q, tick_mode_d;
  logic [7:0]       slice_q, slice_d, ts_q, lock_q, lock_d;
  logic [7:0]       lk_q, lk_d;
  logic             out_valid_q, out_valid_d;
  logic             sw_q, sw_d, any_q, any_d;
  logic [TW-1:0]    nt_q, nt_d;

  logic [6:0]    tid_ext, prio_ext;
  logic          t_ok;
  logic [TW-1:0] tid;
  logic [PW-1:0] prio_sat;
  logic [PW-1:0] top_prio;
  logic [TW-1:0] scan_idx;
  logic [15:0]   dly_dec;
  logic [31:0]   nt_wide, cur_wide;

  assign tid_ext  = {3'b000, task_id_i};
  assign prio_ext = {2'b00, task_prio_i};
  assign t_ok     = tid_ext < 7'(NUM_TASKS);
  assign tid      = TW'(tid_ext);
  assign prio_sat = (prio_ext >= 7'(NUM_PRIOS)) ? PW'(NUM_PRIOS - 1) : PW'(prio_ext);
  assign scan_idx = scan_q[TW-1:0];
  assign dly_dec  = rd_dly_q - 16'd1;

  // Lowest-numbered nonempty priority
  always_comb begin
    top_prio = '0;
    for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        top_prio = PW'(i);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    bitmap_d     = bitmap_q;
    inq_d        = inq_q;
    dlyf_d       = dlyf_q;
    t_work_d     = t_work_q;
    h_d          = h_q;
    cur_d        = cur_q;
    p_push_d     = p_push_q;
    p_work_d     = p_work_q;
    scan_d       = scan_q;
    push_after_d = push_after_q;
    tick_mode_d  = tick_mode_q;
    slice_d      = slice_q;
    lock_d       = lock_q;
    lk_d         = lk_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    sw_d         = sw_q;
    any_d        = any_q;
    nt_d         = nt_q;
    ta = t_work_q; qa = p_work_q; da = scan_idx;
    next_we = 1'b0; prev_we = 1'b0; prio_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; dly_we = 1'b0;
    next_wa = t_work_q; prev_wa = t_work_q; prio_wa = t_work_q; dly_wa = scan_idx;
    next_wd = t_work_q; prev_wd = t_work_q; prio_wd = p_push_q; dly_wd = dly_dec;
    head_wa = p_push_q; tail_wa = p_push_q; head_wd = t_work_q; tail_wd = t_work_q;
    qa_t = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tick_mode_d  = 1'b0;
          push_after_d = 1'b0;
          t_work_d     = tid;
          p_push_d     = prio_sat;
          state_d      = S_SEL;
          unique case (pts_pkg::cmd_e'(cmd_i))
            pts_pkg::CMD_READY: begin
              if (t_ok) begin
                push_after_d = 1'b1;
                state_d      = inq_q[tid] ? S_U0 : S_P0;
              end
            end
            pts_pkg::CMD_REMOVE: begin
              if (t_ok && inq_q[tid]) begin
                state_d = S_U0;
              end
            end
            pts_pkg::CMD_DELAY: begin
              if (t_ok) begin
                dly_we      = 1'b1;
                dly_wa      = tid;
                dly_wd      = delay_ticks_i;
                dlyf_d[tid] = 1'b1;
              end
            end
            pts_pkg::CMD_TICK: begin
              tick_mode_d = 1'b1;
              scan_d      = '0;
              state_d     = S_TSCAN;
            end
            pts_pkg::CMD_LOCK: begin
              if (lock_q != pts_pkg::LockMax) lock_d = lock_q + 8'd1;
            end
            pts_pkg::CMD_UNLOCK: begin
              if (lock_q != 8'd0) lock_d = lock_q - 8'd1;
            end
            pts_pkg::CMD_SCHEDULE, pts_pkg::CMD_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      // Walk the delayed tasks; read count and priority of the next one
      S_TSCAN: begin
        if (scan_q == (TW+1)'(NUM_TASKS)) begin
          if (slice_q == 8'd1) begin
            slice_d = ts_q;
            state_d = S_RPRI;
          end else begin
            slice_d = slice_q - 8'd1;
            state_d = S_SEL;
          end
        end else if (dlyf_q[scan_idx]) begin
          ta      = scan_idx;
          state_d = S_TDEC;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_TDEC: begin
        ta     = scan_idx;
        dly_we = 1'b1;
        scan_d = scan_q + 1'b1;
        if (dly_dec == 16'd0) begin
          dlyf_d[scan_idx] = 1'b0;
          t_work_d     = scan_idx;
          p_push_d     = rd_prio_q;
          push_after_d = 1'b1;
          state_d      = inq_q[scan_idx] ? S_U0 : S_P0;
        end else begin
          state_d = S_TSCAN;
        end
      end
      // Unlink: read links, then queue ends, then patch
      S_U0: state_d = S_U1;
      S_U1: begin
        qa      = rd_prio_q;
        state_d = S_U2;
      end
      S_U2: begin
        qa = rd_prio_q;
        if (rd_head_q == t_work_q && rd_tail_q == t_work_q) begin
          bitmap_d[rd_prio_q] = 1'b0;
        end else begin
          if (rd_head_q == t_work_q) begin
            head_we = 1'b1; head_wa = rd_prio_q; head_wd = rd_next_q;
          end else begin
            next_we = 1'b1; next_wa = rd_prev_q; next_wd = rd_next_q;
          end
          if (rd_tail_q == t_work_q) begin
            tail_we = 1'b1; tail_wa = rd_prio_q; tail_wd = rd_prev_q;
          end else begin
            prev_we = 1'b1; prev_wa = rd_next_q; prev_wd = rd_prev_q;
          end
        end
        inq_d[t_work_q] = 1'b0;
        state_d = push_after_q ? S_P0 : S_SEL;
      end
      // Push at head: read old head, then link in
      S_P0: begin
        qa      = p_push_q;
        state_d = S_P1;
      end
      S_P1: begin
        qa      = p_push_q;
        h_d     = rd_head_q;
        prio_we = 1'b1;
        prev_we = 1'b1;
        next_we = 1'b1;
        head_we = 1'b1;
        inq_d[t_work_q] = 1'b1;
        if (bitmap_q[p_push_q]) begin
          next_wd = rd_head_q;
          state_d = S_P2;
        end else begin
          tail_we = 1'b1;
          bitmap_d[p_push_q] = 1'b1;
          state_d = tick_mode_q ? S_TSCAN : S_SEL;
        end
      end
      S_P2: begin
        prev_we = 1'b1; prev_wa = h_q; prev_wd = t_work_q;
        state_d = tick_mode_q ? S_TSCAN : S_SEL;
      end
      // Slice expiry: rotate the running task's queue
      S_RPRI: begin
        ta      = cur_q;
        state_d = S_R0;
      end
      S_R0: begin
        ta       = cur_q;
        qa       = rd_prio_q;
        p_work_d = rd_prio_q;
        state_d  = bitmap_q[rd_prio_q] ? S_R1 : S_SEL;
      end
      S_R1: begin
        ta      = rd_head_q;
        state_d = (rd_head_q == rd_tail_q) ? S_SEL : S_R2;
      end
      S_R2: begin
        ta      = rd_head_q;
        head_we = 1'b1; head_wa = p_work_q; head_wd = rd_next_q;
        tail_we = 1'b1; tail_wa = p_work_q; tail_wd = rd_head_q;
        next_we = 1'b1; next_wa = rd_tail_q; next_wd = rd_head_q;
        prev_we = 1'b1; prev_wa = rd_head_q; prev_wd = rd_tail_q;
        state_d = S_R3;
      end
      S_R3: begin
        next_we = 1'b1; next_wa = rd_head_q; next_wd = rd_head_q;
        state_d = S_SEL;
      end
      S_SEL: begin
        qa      = top_prio;
        state_d = S_OUT;
      end
      S_OUT: begin
        qa = top_prio;
        if (!out_valid_q || out_ready_i) begin
          any_d = |bitmap_q;
          nt_d  = any_d ? rd_head_q : '0;
          sw_d  = any_d && (lock_q == 8'd0) && (rd_head_q != cur_q);
          if (sw_d) cur_d = rd_head_q;
          // Capture the lock depth with the item so it holds while the item waits
          lk_d        = lock_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    qa_t = h_q;
  end

  // Memories: synchronous write, registered read-first data
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prio_we) prio_mem[prio_wa] <= prio_wd;
    rd_next_q <= next_mem[ta];
    rd_prev_q <= prev_mem[ta];
    rd_prio_q <= prio_mem[ta];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    rd_head_q <= head_mem[qa];
    rd_tail_q <= tail_mem[qa];
  end

  always_ff @(posedge clk_i) begin
    if (dly_we) dly_mem[dly_wa] <= dly_wd;
    rd_dly_q <= dly_mem[da];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bitmap_q     <= '0;
      inq_q        <= '0;
      dlyf_q       <= '0;
      cur_q        <= '0;
      scan_q       <= '0;
      push_after_q <= 1'b0;
      tick_mode_q  <= 1'b0;
      slice_q      <= pts_pkg::SliceReset;
      ts_q         <= pts_pkg::SliceReset;
      lock_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bitmap_q     <= bitmap_d;
      inq_q        <= inq_d;
      dlyf_q       <= dlyf_d;
      cur_q        <= cur_d;
      scan_q       <= scan_d;
      push_after_q <= push_after_d;
      tick_mode_q  <= tick_mode_d;
      slice_q      <= slice_d;
      lock_q       <= lock_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) ts_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    t_work_q <= t_work_d;
    h_q      <= (qa_t == h_d) ? qa_t : h_d;
    p_push_q <= p_push_d;
    p_work_q <= p_work_d;
    sw_q     <= sw_d;
    any_q    <= any_d;
    nt_q     <= nt_d;
    lk_q     <= lk_d;
  end

  assign nt_wide  = 32'(nt_q);
  assign cur_wide = 32'(cur_q);

  assign out_valid_o    = out_valid_q;
  assign switch_now_o   = sw_q;
  assign next_task_o    = nt_wide[3:0];
  assign running_task_o = cur_wide[3:0];
  assign lock_depth_o   = lk_q;
  assign any_ready_o    = any_q;

endmodule

### hw/rtl/pts_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       switch_now_o,
  input logic [3:0] next_task_o,
  input logic [3:0] running_task_o,
  input logic [7:0] lock_depth_o,
  input logic       any_ready_o
);

  `PTS_ASSERT_IMPL(sw_sets_running, clk_i, rst_ni, out_valid_o && switch_now_o, running_task_o == next_task_o, "switch without running task update")
  `PTS_ASSERT_IMPL(no_sw_locked, clk_i, rst_ni, out_valid_o && lock_depth_o != 8'd0, !switch_now_o, "switch while locked")
  `PTS_ASSERT_IMPL(idle_no_task, clk_i, rst_ni, out_valid_o && !any_ready_o, !switch_now_o && next_task_o == 4'd0, "switch or task with empty queues")
  `PTS_ASSERT_NEXT(out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(running_task_o), "result dropped while stalled")

endmodule

bind priority_task_scheduler_core pts_checker u_pts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .switch_now_o   (switch_now_o),
  .next_task_o    (next_task_o),
  .running_task_o (running_task_o),
  .lock_depth_o   (lock_depth_o),
  .any_ready_o    (any_ready_o)
);
